@@ hw/rtl/tgi_pkg.sv @@
// Shared types, constants and arithmetic helpers for the trilinear grid interpolator.
// Used by trilinear_grid_interpolator and its port checker; depends on nothing else.
package tgi_pkg;

  localparam int DIM_W           = 9;
  localparam int DIM_MAX         = 256;
  localparam int GRID_POINTS_DEF = 65536;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_INV_SPACING,
    REG_DIM_X,
    REG_DIM_Y,
    REG_DIM_Z
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE,
    OP_QUERY
  } op_e;

  // Per-item control carried down the query pipeline.
  typedef struct packed {
    logic        qry;
    logic        ok;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] fz;
  } meta_t;

  typedef struct packed {
    logic             ok;
    logic [DIM_W-1:0] cidx;
    logic [15:0]      frac;
  } ax_t;

  // Grid units are u - 0.5 clamped at zero; the point must stay below the last cell edge.
  function automatic ax_t map_ax(input logic [55:0] u, input logic dpos,
                                 input logic [DIM_W-1:0] dim);
    ax_t         r;
    logic [55:0] g;
    g = (u < 56'h80000000) ? '0 : u - 56'h80000000;
    r.ok   = dpos && (dim >= DIM_W'(2)) && (32'(dim) <= DIM_MAX) &&
             (u[55:32] < 24'(dim - DIM_W'(1)));
    r.cidx = g[32+DIM_W-1:32];
    r.frac = g[31:16];
    return r;
  endfunction

  function automatic logic signed [50:0] fmul(input logic [15:0] f,
                                              input logic signed [33:0] d);
    return $signed({1'b0, f}) * d;
  endfunction

  // Add one half and take the floor of the Q16.16 product.
  function automatic logic signed [34:0] rnd16(input logic signed [50:0] x);
    logic signed [50:0] s;
    s = x + 51'sd32768;
    return s[50:16];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'h7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

endpackage

@@ hw/rtl/trilinear_grid_interpolator.sv @@
// Top level of the trilinear grid interpolator: configuration, sample store and query pipeline.
// Depends on tgi_pkg.
//
// The block takes one transfer per cycle while the output is not stalled, sample writes and
// point queries mixed freely, and returns a result for each query that it takes. The
// sample store is held as eight identical synchronous copies, written together, so the eight
// corners of a cell are read in the same cycle; writes and reads use the same pipeline stage, so a
// query always sees every write taken before it. A stalled output holds the whole pipeline.
// Derived grid sizes are registered from the configuration registers, the y-z product first.
// The store has no clearing pass: samples read before they are written are undefined.
module trilinear_grid_interpolator
  import tgi_pkg::*;
#(
  parameter int GRID_POINTS = GRID_POINTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [15:0]           address_i,
  input  logic signed [31:0]    sample_i,
  input  logic signed [31:0]    pos_x_i,
  input  logic signed [31:0]    pos_y_i,
  input  logic signed [31:0]    pos_z_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  inside_res_o,
  output logic signed [31:0]    level_o,
  output logic signed [31:0]    grad_x_o,
  output logic signed [31:0]    grad_y_o,
  output logic signed [31:0]    grad_z_o
);

  localparam int AW = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;

  // Configuration registers.
  logic signed [31:0] org_x_q, org_y_q, org_z_q;
  logic [23:0]        inv_q;
  logic [DIM_W-1:0]   dim_x_q, dim_y_q, dim_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      inv_q   <= 24'd65536;
      dim_x_q <= '0;
      dim_y_q <= '0;
      dim_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ORIGIN_X:    org_x_q <= cfg_data_i;
        REG_ORIGIN_Y:    org_y_q <= cfg_data_i;
        REG_ORIGIN_Z:    org_z_q <= cfg_data_i;
        REG_INV_SPACING: inv_q   <= cfg_data_i[23:0];
        REG_DIM_X:       dim_x_q <= cfg_data_i[DIM_W-1:0];
        REG_DIM_Y:       dim_y_q <= cfg_data_i[DIM_W-1:0];
        REG_DIM_Z:       dim_z_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Grid sizes and corner offsets, recomputed every cycle from the registers.
  logic [17:0] yz_q;
  logic [26:0] ntot_q;
  logic [27:0] off_q [8];

  always_ff @(posedge clk_i) begin
    yz_q     <= 18'(dim_y_q) * 18'(dim_z_q);
    ntot_q   <= 27'(yz_q) * 27'(dim_x_q);
    off_q[0] <= '0;
    off_q[1] <= 28'd1;
    off_q[2] <= 28'(dim_z_q);
    off_q[3] <= 28'(dim_z_q) + 28'd1;
    off_q[4] <= 28'(yz_q);
    off_q[5] <= 28'(yz_q) + 28'd1;
    off_q[6] <= 28'(yz_q) + 28'(dim_z_q);
    off_q[7] <= 28'(yz_q) + 28'(dim_z_q) + 28'd1;
  end

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic [12:0] v_q;
  logic        out_vld_q;
  meta_t       m_q [3:12];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q       <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v_q       <= {v_q[11:0], in_valid_i};
      out_vld_q <= v_q[12] && m_q[12].qry;
    end
  end

  // Front end: map the point to a cell and fractions.
  logic               op0_q, op1_q, op2_q;
  logic [15:0]        addr0_q, addr1_q, addr2_q, addr3_q, addr4_q, addr5_q;
  logic signed [31:0] smp0_q, smp1_q, smp2_q, smp3_q, smp4_q, smp5_q;
  logic signed [31:0] px0_q, py0_q, pz0_q;
  logic signed [32:0] dx1_q, dy1_q, dz1_q;
  logic [55:0]        ux2_q, uy2_q, uz2_q;
  logic               posx2_q, posy2_q, posz2_q;
  logic [DIM_W-1:0]   cx3_q, cy3_q, cz3_q, cz4_q;
  logic [26:0]        px4_q;
  logic [17:0]        py4_q;
  logic [27:0]        n5_q;
  ax_t                ax_x, ax_y, ax_z;

  // Corner addresses; the last one is the far corner that bounds the check.
  logic [27:0]   corner [8];

  always_comb begin
    ax_x = map_ax(ux2_q, posx2_q, dim_x_q);
    ax_y = map_ax(uy2_q, posy2_q, dim_y_q);
    ax_z = map_ax(uz2_q, posz2_q, dim_z_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q   <= operation_i;
      addr0_q <= address_i;
      smp0_q  <= sample_i;
      px0_q   <= pos_x_i;
      py0_q   <= pos_y_i;
      pz0_q   <= pos_z_i;

      op1_q   <= op0_q;
      addr1_q <= addr0_q;
      smp1_q  <= smp0_q;
      dx1_q   <= 33'(px0_q) - 33'(org_x_q);
      dy1_q   <= 33'(py0_q) - 33'(org_y_q);
      dz1_q   <= 33'(pz0_q) - 33'(org_z_q);

      op2_q   <= op1_q;
      addr2_q <= addr1_q;
      smp2_q  <= smp1_q;
      ux2_q   <= 56'(dx1_q[31:0]) * 56'(inv_q);
      uy2_q   <= 56'(dy1_q[31:0]) * 56'(inv_q);
      uz2_q   <= 56'(dz1_q[31:0]) * 56'(inv_q);
      posx2_q <= !dx1_q[32] && (dx1_q != '0);
      posy2_q <= !dy1_q[32] && (dy1_q != '0);
      posz2_q <= !dz1_q[32] && (dz1_q != '0);

      addr3_q  <= addr2_q;
      smp3_q   <= smp2_q;
      cx3_q    <= ax_x.cidx;
      cy3_q    <= ax_y.cidx;
      cz3_q    <= ax_z.cidx;
      m_q[3]   <= '{qry: (op_e'(op2_q) == OP_QUERY), ok: ax_x.ok && ax_y.ok && ax_z.ok,
                    fx: ax_x.frac, fy: ax_y.frac, fz: ax_z.frac};

      addr4_q <= addr3_q;
      smp4_q  <= smp3_q;
      px4_q   <= 27'(cx3_q) * 27'(yz_q);
      py4_q   <= 18'(cy3_q) * 18'(dim_z_q);
      cz4_q   <= cz3_q;

      addr5_q <= addr4_q;
      smp5_q  <= smp4_q;
      n5_q    <= 28'(px4_q) + 28'(py4_q) + 28'(cz4_q);

      for (int k = 4; k <= 5; k++) begin
        m_q[k] <= m_q[k-1];
      end
      m_q[6] <= '{qry: m_q[5].qry,
                  ok: m_q[5].ok && (corner[7] < 28'(ntot_q)) &&
                      (32'(corner[7]) < GRID_POINTS),
                  fx: m_q[5].fx, fy: m_q[5].fy, fz: m_q[5].fz};
      for (int k = 7; k <= 12; k++) begin
        m_q[k] <= m_q[k-1];
      end
    end
  end

  logic [AW-1:0] ad6_q [8];
  logic          wr6_q;
  logic [AW-1:0] wa6_q;
  logic [31:0]   wd6_q;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      corner[k] = n5_q + off_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        ad6_q[k] <= AW'(corner[k]);
      end
      wr6_q <= !m_q[5].qry && (32'(addr5_q) < GRID_POINTS);
      wa6_q <= AW'(addr5_q);
      wd6_q <= smp5_q;
    end
  end

  // Eight copies of the sample store, one read port each.
  logic signed [31:0] rd7_q [8];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [31:0] mem [GRID_POINTS];

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (v_q[6] && wr6_q) begin
          mem[wa6_q] <= wd6_q;
        end
        rd7_q[b] <= mem[ad6_q[b]];
      end
    end
  end

  // Blend pipeline: z, then y, then x; differences ride along for the gradients.
  logic signed [33:0] d7 [4];
  logic signed [50:0] zp8_q [4];
  logic signed [33:0] ve8_q [4], dd8_q [4];
  logic signed [33:0] a9_q [4], qb9_q [2];
  logic signed [50:0] qp9_q [2];
  logic signed [33:0] e10_q [2], ab10_q [2], q10_q [2];
  logic signed [50:0] pp10_q [2];
  logic signed [33:0] p11_q [2], e0_11_q, q0_11_q;
  logic signed [50:0] gyp11_q, gzp11_q;
  logic signed [50:0] lvp12_q;
  logic signed [33:0] p0_12_q;
  logic [31:0]        gx12_q, gy12_q, gz12_q;
  logic               ins_q;
  logic [31:0]        lev_q, gxo_q, gyo_q, gzo_q;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      d7[j] = 34'(rd7_q[2*j+1]) - 34'(rd7_q[2*j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        zp8_q[j] <= fmul(m_q[7].fz, d7[j]);
        ve8_q[j] <= 34'(rd7_q[2*j]);
        dd8_q[j] <= d7[j];
        a9_q[j]  <= ve8_q[j] + 34'(rnd16(zp8_q[j]));
      end
      for (int j = 0; j < 2; j++) begin
        qp9_q[j]  <= fmul(m_q[8].fy, dd8_q[2*j+1] - dd8_q[2*j]);
        qb9_q[j]  <= dd8_q[2*j];
        e10_q[j]  <= a9_q[2*j+1] - a9_q[2*j];
        pp10_q[j] <= fmul(m_q[9].fy, a9_q[2*j+1] - a9_q[2*j]);
        ab10_q[j] <= a9_q[2*j];
        q10_q[j]  <= qb9_q[j] + 34'(rnd16(qp9_q[j]));
        p11_q[j]  <= ab10_q[j] + 34'(rnd16(pp10_q[j]));
      end
      gyp11_q <= fmul(m_q[10].fx, e10_q[1] - e10_q[0]);
      e0_11_q <= e10_q[0];
      gzp11_q <= fmul(m_q[10].fx, q10_q[1] - q10_q[0]);
      q0_11_q <= q10_q[0];

      lvp12_q <= fmul(m_q[11].fx, p11_q[1] - p11_q[0]);
      p0_12_q <= p11_q[0];
      gx12_q  <= sat32(35'(p11_q[1]) - 35'(p11_q[0]));
      gy12_q  <= sat32(35'(e0_11_q) + rnd16(gyp11_q));
      gz12_q  <= sat32(35'(q0_11_q) + rnd16(gzp11_q));

      // A point outside the grid returns all zeros.
      ins_q <= m_q[12].ok;
      if (m_q[12].ok) begin
        lev_q <= 32'(p0_12_q + 34'(rnd16(lvp12_q)));
        gxo_q <= gx12_q;
        gyo_q <= gy12_q;
        gzo_q <= gz12_q;
      end else begin
        lev_q <= '0;
        gxo_q <= '0;
        gyo_q <= '0;
        gzo_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign inside_res_o = ins_q;
  assign level_o      = lev_q;
  assign grad_x_o     = gxo_q;
  assign grad_y_o     = gyo_q;
  assign grad_z_o     = gzo_q;

endmodule

@@ hw/rtl/tgi_port_checker.sv @@
// Port-level checks for the trilinear grid interpolator, bound to the top level.
// Depends on tgi_pkg and trilinear_grid_interpolator.
module tgi_port_checker
  import tgi_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               inside_res_o,
  input logic signed [31:0] level_o,
  input logic signed [31:0] grad_x_o,
  input logic signed [31:0] grad_y_o,
  input logic signed [31:0] grad_z_o
);

  // The input side only stalls while a finished result is held up.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // A result outside the grid carries only zeros.
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !inside_res_o) |->
      (level_o == '0 && grad_x_o == '0 && grad_y_o == '0 && grad_z_o == '0))
    else $error("outside result is not zero");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_hold_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(level_o) && $stable(grad_z_o)))
    else $error("stalled result changed");

endmodule

bind trilinear_grid_interpolator tgi_port_checker u_tgi_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .inside_res_o (inside_res_o),
  .level_o      (level_o),
  .grad_x_o     (grad_x_o),
  .grad_y_o     (grad_y_o),
  .grad_z_o     (grad_z_o)
);

@@ verif/trilinear_grid_interpolator_tb.sv @@
// Self-checking testbench for trilinear_grid_interpolator: sample writes and point queries
// are driven under random idling and checked against a scoreboard that predicts each result.
// Depends on tgi_pkg and the trilinear_grid_interpolator RTL.

typedef struct {
  logic        in_grid;
  logic [31:0] level;
  logic [31:0] gx;
  logic [31:0] gy;
  logic [31:0] gz;
} grid_result_t;

class grid_scoreboard;
  int           samples [65536];
  bit           written [65536];
  longint       org_x, org_y, org_z;
  longint       inv_sp;
  int           dx, dy, dz;
  grid_result_t pending_q[$];
  int           mismatches;

  function new();
    org_x = 0; org_y = 0; org_z = 0;
    inv_sp = 65536;
    dx = 0; dy = 0; dz = 0;
    mismatches = 0;
  endfunction

  function void set_reg(tgi_pkg::cfg_reg_e idx, logic [31:0] data);
    case (idx)
      tgi_pkg::REG_ORIGIN_X:    org_x = longint'($signed(data));
      tgi_pkg::REG_ORIGIN_Y:    org_y = longint'($signed(data));
      tgi_pkg::REG_ORIGIN_Z:    org_z = longint'($signed(data));
      tgi_pkg::REG_INV_SPACING: inv_sp = longint'(data[23:0]);
      tgi_pkg::REG_DIM_X:       dx = int'(data[8:0]);
      tgi_pkg::REG_DIM_Y:       dy = int'(data[8:0]);
      tgi_pkg::REG_DIM_Z:       dz = int'(data[8:0]);
      default: ;
    endcase
  endfunction

  function bit map_axis(longint p, longint o, int dim, output longint cidx,
                        output longint frac);
    longint d, u, g;
    d = p - o;
    cidx = 0;
    frac = 0;
    if (dim < 2 || dim > 256 || d <= 0) return 0;
    u = d * inv_sp;
    if (u >= longint'(dim - 1) * 64'sd4294967296) return 0;
    g = u - 64'sd2147483648;
    if (g < 0) g = 0;
    cidx = g >>> 32;
    frac = (g >>> 16) & 64'hFFFF;
    return 1;
  endfunction

  // Returns 1 when the query reads the store; corner indices in x-major order.
  function bit find_cell(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                         output longint idx[8], output longint fx, output longint fy,
                         output longint fz);
    longint cx, cy, cz, yz, n;
    bit     ok;
    ok = map_axis(longint'($signed(px)), org_x, dx, cx, fx);
    ok = ok && map_axis(longint'($signed(py)), org_y, dy, cy, fy);
    ok = ok && map_axis(longint'($signed(pz)), org_z, dz, cz, fz);
    if (!ok) return 0;
    yz = longint'(dy) * dz;
    n = cx * yz + cy * dz + cz;
    idx[0] = n;            idx[1] = n + 1;
    idx[2] = n + dz;       idx[3] = n + 1 + dz;
    idx[4] = n + yz;       idx[5] = n + 1 + yz;
    idx[6] = n + dz + yz;  idx[7] = n + 1 + dz + yz;
    return !(idx[7] >= yz * dx || idx[7] >= 65536);
  endfunction

  function longint blend(longint a, longint b, longint f);
    return ((65536 - f) * a + f * b + 32768) >>> 16;
  endfunction

  function logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function void note_transfer(tgi_pkg::op_e op, logic [15:0] addr, logic [31:0] smp,
                              logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    grid_result_t r;
    longint       idx[8];
    longint       v[8];
    longint       fx, fy, fz, a00, a01, a10, a11, p0, p1, q0, q1;
    if (op == tgi_pkg::OP_WRITE) begin
      samples[addr] = $signed(smp);
      written[addr] = 1;
      return;
    end
    r = '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0};
    if (find_cell(px, py, pz, idx, fx, fy, fz)) begin
      foreach (v[k]) v[k] = longint'(samples[idx[k]]);
      a00 = blend(v[0], v[1], fz);
      a01 = blend(v[2], v[3], fz);
      a10 = blend(v[4], v[5], fz);
      a11 = blend(v[6], v[7], fz);
      p0 = blend(a00, a01, fy);
      p1 = blend(a10, a11, fy);
      q0 = blend(v[1] - v[0], v[3] - v[2], fy);
      q1 = blend(v[5] - v[4], v[7] - v[6], fy);
      r.in_grid = 1;
      r.level = 32'(blend(p0, p1, fx));
      r.gx = clip32(p1 - p0);
      r.gy = clip32(blend(a01 - a00, a11 - a10, fx));
      r.gz = clip32(blend(q0, q1, fx));
    end
    pending_q = {pending_q, r};
  endfunction

  function void check_result(grid_result_t got);
    grid_result_t exp_r;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result with no query pending");
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.in_grid !== exp_r.in_grid || got.level !== exp_r.level || got.gx !== exp_r.gx ||
        got.gy !== exp_r.gy || got.gz !== exp_r.gz) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: expected inside=%0b level=%h gx=%h gy=%h gz=%h", exp_r.in_grid,
                 exp_r.level, exp_r.gx, exp_r.gy, exp_r.gz);
        $display("       actual   inside=%0b level=%h gx=%h gy=%h gz=%h", got.in_grid,
                 got.level, got.gx, got.gy, got.gz);
      end
    end
  endfunction
endclass

module trilinear_grid_interpolator_tb;
  import tgi_pkg::*;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  cfg_we_i = 0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 0;
  logic                  in_stall_o;
  logic                  operation_i = 0;
  logic [15:0]           address_i = '0;
  logic signed [31:0]    sample_i = '0;
  logic signed [31:0]    pos_x_i = '0;
  logic signed [31:0]    pos_y_i = '0;
  logic signed [31:0]    pos_z_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 0;
  logic                  inside_res_o;
  logic signed [31:0]    level_o;
  logic signed [31:0]    grad_x_o;
  logic signed [31:0]    grad_y_o;
  logic signed [31:0]    grad_z_o;

  grid_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  transfers_in = 0;
  int  quiet_cycles = 0;
  bit  held_off = 0;

  trilinear_grid_interpolator uut (.*);

  always #10 clk_i = ~clk_i;

  // Receiver: random stall, plus one long hold-off that backs the pipeline up.
  always @(posedge clk_i) begin
    if (!held_off && transfers_in >= 400) begin
      held_off = 1;
      out_stall_i <= 1;
      repeat (300) @(posedge clk_i);
      out_stall_i <= 0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      sb.check_result('{inside_res_o, level_o, grad_x_o, grad_y_o, grad_z_o});
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= 5000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(op_e op, logic [15:0] addr, logic [31:0] smp,
                      logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i  <= 1;
    operation_i <= op;
    address_i   <= addr;
    sample_i    <= smp;
    pos_x_i     <= px;
    pos_y_i     <= py;
    pos_z_i     <= pz;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transfer(op, addr, smp, px, py, pz);
    transfers_in++;
  endtask

  task automatic write_sample(logic [15:0] addr, logic [31:0] smp);
    send(OP_WRITE, addr, smp, $urandom, $urandom, $urandom);
  endtask

  // Any corner of the cell not yet stored gets a sample first.
  task automatic query(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    longint idx[8];
    longint fx, fy, fz;
    if (sb.find_cell(px, py, pz, idx, fx, fy, fz)) begin
      foreach (idx[k]) begin
        if (!sb.written[idx[k]]) write_sample(16'(idx[k]), random_sample());
      end
    end
    send(OP_QUERY, 16'($urandom), $urandom, px, py, pz);
  endtask

  function automatic logic [31:0] random_sample();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(32'h0003_0000);
      default: return $urandom;
    endcase
  endfunction

  // A point whose grid coordinate lands inside the box when the configuration allows it.
  function automatic logic [31:0] inner_pos(longint o, int dim);
    longint maxd, d, p;
    if (dim < 2 || dim > 256) return $urandom;
    if (sb.inv_sp == 0) maxd = 64'h7FFF_FFFF;
    else maxd = ((longint'(dim - 1) << 32) - 1) / sb.inv_sp;
    if (maxd < 1) return $urandom;
    d = (longint'({$urandom, $urandom}) & 64'h7FFF_FFFF_FFFF_FFFF) % maxd + 1;
    p = o + d;
    if (p > 64'sd2147483647) return $urandom;
    return p[31:0];
  endfunction

  // The write enable stays high over a run of writes; the caller lowers it afterwards.
  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [23:0] inv, logic [8:0] nx, logic [8:0] ny, logic [8:0] nz);
    drain();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_INV_SPACING, {8'h0, inv});
    write_reg(REG_DIM_X, {23'h0, nx});
    write_reg(REG_DIM_Y, {23'h0, ny});
    write_reg(REG_DIM_Z, {23'h0, nz});
    cfg_we_i <= 0;
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return $urandom;
      default: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [23:0] pick_inv();
    case ($urandom_range(5))
      0: return 24'h0;
      1: return 24'hFF_FFFF;
      2: return 24'h1;
      3: return 24'h01_0000;
      default: return $urandom_range(24'h04_0000, 24'h00_4000);
    endcase
  endfunction

  function automatic logic [8:0] pick_dim();
    case ($urandom_range(9))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd256;
      3: return 9'h1FF;
      default: return $urandom_range(6, 2);
    endcase
  endfunction

  initial begin
    int n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: a single 2x2x2 cell at unit spacing with extreme corner values.
    configure(32'h0, 32'h0, 32'h0, 24'h01_0000, 9'd2, 9'd2, 9'd2);
    write_reg(cfg_reg_e'(3'd7), 32'hFFFF_FFFF);
    cfg_we_i <= 0;
    for (int k = 0; k < 8; k++) write_sample(16'(k), k[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
    query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    query(32'h0000_C000, 32'h0000_4000, 32'h0000_E000);
    query(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
    query(32'h0001_0000, 32'h0000_8000, 32'h0000_8000);
    query(32'h0, 32'h0000_8000, 32'h0000_8000);
    query(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    query(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    write_sample(16'hFFFF, 32'h1234_5678);
    write_sample(16'd3, 32'h0);
    query(32'h0000_9000, 32'h0000_7000, 32'h0000_A000);

    // Zero spacing reciprocal and a dimension above the maximum.
    configure(32'hFFFF_0000, 32'h0, 32'h0, 24'h0, 9'd2, 9'd2, 9'd2);
    query(32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0100);
    configure(32'h0, 32'h0, 32'h0, 24'h01_0000, 9'd300, 9'd2, 9'd2);
    query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    // Far corner beyond the store.
    configure(32'h0, 32'h0, 32'h0, 24'h01_0000, 9'd256, 9'd256, 9'd2);
    query(32'h00C8_8000, 32'h0000_8000, 32'h0000_8000);
    query(32'h0000_8000, 32'h00FE_8000, 32'h0000_8000);

    // Each phase runs until its share of transfers is in, corner writes included.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) configure(32'h8000_0000, 32'h0, 32'h7FFF_0000, 24'hFF_FFFF,
                                9'd3, 9'd4, 9'd5);
      else if (phase == 1) configure(32'h0, 32'h0, 32'h0, 24'h00_8000, 9'd256, 9'd2, 9'd2);
      else configure(pick_origin(), pick_origin(), pick_origin(), pick_inv(),
                     pick_dim(), pick_dim(), pick_dim());
      while (transfers_in < (phase + 1) * 235) begin
        n = transfers_in;
        send_idle_pct = (n < 600) ? 9 : (n < 1200) ? 45 : 0;
        recv_idle_pct = (n < 600) ? 45 : (n < 1200) ? 9 : 0;
        case ($urandom_range(9))
          0, 1: write_sample(16'($urandom), random_sample());
          2: query($urandom, $urandom, $urandom);
          default: query(inner_pos(sb.org_x, sb.dx), inner_pos(sb.org_y, sb.dy),
                         inner_pos(sb.org_z, sb.dz));
        endcase
      end
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
